[rtl/core/ssc_pkg.sv]
// Shared types for the subset-sum counter: request and result payloads,
// controller states, and the command/status bundles between control and datapath.
// No dependencies.
package ssc_pkg;

  typedef struct packed {
    logic [15:0] element;
    logic        last_element;
  } elem_req_t;

  typedef struct packed {
    logic        subset_exists;
    logic [31:0] subset_count;
    logic        count_saturated;
  } result_t;

  typedef struct packed {
    logic [7:0] target_sum;
  } cfg_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic walk_step;
    logic rd_result;
    logic load_out;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic in_skip;
    logic in_last;
    logic walk_end;
    logic last_held;
    logic clr_end;
    logic out_busy;
  } status_t;

endpackage

[rtl/core/ssc_stream_if.sv]
// Valid/ready channel with a typed payload, used for every port of the block.
// No dependencies.
interface ssc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/subset_sum_checker_counter.sv]
// Subset-sum counter top level: ties the controller and datapath to the channels.
// Depends on ssc_pkg, ssc_stream_if, ssc_ctrl and ssc_datapath.
//
//   channel  dir  payload                                          handshake
//   elem     in   element[15:0], last_element                      valid/ready
//   result   out  subset_exists, subset_count[31:0], count_saturated  valid/ready
//   cfg      in   target_sum[7:0]                                  valid/ready (ready=1)
//
// An element walks the table from min(target,SUM_MAX) down to the element,
// one table entry updated per cycle on the count memory, then drains; zero
// or oversized elements skip the walk. A last element adds a table read and
// a result load; the result is valid from the cycle after the load. After
// reset and after each result, a clear sweep over all SUM_MAX+1 entries runs
// with elem.ready low. A waiting result holds only a following last element.
module subset_sum_checker_counter #(
  parameter int SUM_MAX     = 255,
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  ssc_stream_if.sink   elem,
  ssc_stream_if.source result,
  ssc_stream_if.sink   cfg
);
  import ssc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (elem.valid),
    .in_ready (elem.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssc_datapath #(
    .SUM_MAX     (SUM_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg.valid),
    .cfg_target   (cfg.data.target_sum),
    .element      (elem.data.element),
    .last_element (elem.data.last_element),
    .cmd          (cmd),
    .status       (status),
    .result       (result)
  );

endmodule

[rtl/core/ssc_ctrl.sv]
// Sequencer for the subset-sum counter: clear sweep, table walk, result read.
// Depends on ssc_pkg.
module ssc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssc_pkg::status_t status,
  output ssc_pkg::cmd_t    cmd
);
  import ssc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (!status.in_skip) state_next = ST_WALK;
          else if (status.in_last) state_next = ST_READ;
        end
      end
      ST_WALK: begin
        if (status.walk_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = status.last_held ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_busy) state_next = ST_CLEAR;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_WALK:   cmd.walk_step = 1'b1;
      ST_DRAIN:  ;
      ST_READ:   cmd.rd_result = 1'b1;
      ST_RESULT: cmd.load_out = !status.out_busy;
      default:   ;
    endcase
  end

endmodule

[rtl/core/ssc_datapath.sv]
// Count table memory, walk address counter, saturating adder, clear sweep,
// target register and result register. Depends on ssc_pkg and ssc_stream_if.
module ssc_datapath #(
  parameter int SUM_MAX     = 255,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [7:0]         cfg_target,
  input  logic [15:0]        element,
  input  logic               last_element,
  input  ssc_pkg::cmd_t      cmd,
  output ssc_pkg::status_t   status,
  ssc_stream_if.source       result
);
  import ssc_pkg::*;

  localparam int DEPTH = SUM_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = (AW > 8) ? AW : 8;
  localparam int CW    = COUNT_WIDTH;

  logic [CW-1:0] mem [DEPTH];

  logic [7:0]    target;
  logic [15:0]   elem_q;
  logic          last_q;
  logic [AW-1:0] j;
  logic [AW-1:0] clr_addr;
  logic          p1_valid;
  logic [AW-1:0] p1_addr;
  logic [CW-1:0] rd_a;
  logic [CW-1:0] rd_b;
  logic          sat_seen;
  logic          res_valid;
  result_t       res;

  logic [TW-1:0] tgt_x;
  logic          in_range;
  logic [AW-1:0] top;
  logic [AW-1:0] e_addr;
  logic [AW-1:0] addr_a;
  logic [CW:0]   sum;
  logic [CW-1:0] wr_data;
  logic [63:0]   cnt64;
  logic          cnt_hi;

  assign tgt_x    = TW'(target);
  assign in_range = tgt_x <= TW'(SUM_MAX);
  assign top      = in_range ? tgt_x[AW-1:0] : AW'(SUM_MAX);
  assign e_addr   = elem_q[AW-1:0];
  assign addr_a   = cmd.walk_step ? j : tgt_x[AW-1:0];
  assign sum      = {1'b0, rd_a} + {1'b0, rd_b};
  assign wr_data  = sum[CW] ? '1 : sum[CW-1:0];
  assign cnt64    = in_range ? 64'(rd_a) : 64'd0;
  assign cnt_hi   = |cnt64[63:32];

  assign status.in_skip   = (element == 16'd0) || (element > 16'(top));
  assign status.in_last   = last_element;
  assign status.walk_end  = (j == e_addr);
  assign status.last_held = last_q;
  assign status.clr_end   = (clr_addr == AW'(DEPTH - 1));
  assign status.out_busy  = res_valid;

  assign result.valid = res_valid;
  assign result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= 8'd0;
    end else if (cfg_wr) begin
      target <= cfg_target;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elem_q <= element;
      last_q <= last_element;
      j      <= top;
    end else if (cmd.walk_step) begin
      j <= j - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= status.clr_end ? '0 : clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) p1_addr <= j;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= (clr_addr == '0) ? CW'(1) : '0;
    end else if (p1_valid) begin
      mem[p1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step || cmd.rd_result) rd_a <= mem[addr_a];
    if (cmd.walk_step) rd_b <= mem[j - e_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_step) begin
      sat_seen <= 1'b0;
    end else if (p1_valid && sum[CW]) begin
      sat_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.subset_exists   <= (cnt64 != 64'd0);
      res.subset_count    <= cnt_hi ? 32'hFFFF_FFFF : cnt64[31:0];
      res.count_saturated <= sat_seen | cnt_hi;
    end
  end

  a_no_walk_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_step && p1_valid))
    else $error("walk write collides with clear sweep");

  a_load_into_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !res_valid)
    else $error("result register overwritten");

  a_walk_stays_above_elem: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> (j >= e_addr) && (e_addr != '0))
    else $error("walk address below element");

  a_walk_after_clear_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_step && status.clr_end) |=> !cmd.clr_step)
    else $error("clear sweep ran past the table end");

endmodule
